// ===== design/ssfl_pkg.sv =====
// Shared types, constants and helpers for the substring search core.
package ssfl_pkg;

  localparam int unsigned NEEDLE_MAX_DEF = 8;
  localparam longint unsigned MAX_STRING_DEF = 64'd65536;

  localparam int unsigned NEEDLE_W = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned SEEN_W   = 17;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SEEN_W-1:0] SEEN_LIMIT = '1;
  localparam logic [POS_W-1:0]  POS_LIMIT  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEEDLE_CHARS   = 2'd0,
    REG_NEEDLE_LENGTH  = 2'd1,
    REG_CASE_SENSITIVE = 2'd2,
    REG_FIND_LAST      = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_FOUND        = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_EMPTY_HAY    = 2'd2,
    ST_EMPTY_NEEDLE = 2'd3
  } status_t;

  typedef struct packed {
    logic [NEEDLE_W-1:0] needle_chars;
    logic [LEN_W-1:0]    needle_length;
    logic                case_sensitive;
    logic                find_last;
  } cfg_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    fold_char = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'd32) : c;
  endfunction

  function automatic logic chars_equal(input logic [7:0] a, input logic [7:0] b,
                                       input logic exact);
    chars_equal = exact ? (a == b) : (fold_char(a) == fold_char(b));
  endfunction

endpackage

// ===== design/ssfl_cfg.sv =====
// Configuration register file for the substring search core.
module ssfl_cfg
  import ssfl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_enable,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NEEDLE_W-1:0]  cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.needle_chars   <= '0;
      cfg.needle_length  <= '0;
      cfg.case_sensitive <= 1'b1;
      cfg.find_last      <= 1'b0;
    end else if (cfg_write_enable) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NEEDLE_CHARS:   cfg.needle_chars   <= cfg_data;
        REG_NEEDLE_LENGTH:  cfg.needle_length  <= cfg_data[LEN_W-1:0];
        REG_CASE_SENSITIVE: cfg.case_sensitive <= cfg_data[0];
        REG_FIND_LAST:      cfg.find_last      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/ssfl_window.sv =====
// Sliding character window and parallel needle compare.
module ssfl_window
  import ssfl_pkg::*;
#(
  parameter int unsigned NEEDLE_MAX = NEEDLE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             clear,
  input  logic [7:0]       symbol,
  input  cfg_t             cfg,
  input  logic [LEN_W-1:0] act_len,
  output logic             hit
);

  logic [7:0] window  [NEEDLE_MAX];
  logic [7:0] shifted [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] len_hit;

  // newest character first
  always_comb begin
    shifted[0] = symbol;
    for (int j = 1; j < NEEDLE_MAX; j++) shifted[j] = window[j-1];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int j = 0; j < NEEDLE_MAX; j++) window[j] <= '0;
    end else if (advance) begin
      for (int j = 0; j < NEEDLE_MAX; j++) window[j] <= shifted[j];
    end
  end

  // one compare row per candidate needle length
  always_comb begin
    for (int l = 1; l <= NEEDLE_MAX; l++) begin
      len_hit[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (!chars_equal(shifted[l-1-k], cfg.needle_chars[8*k +: 8], cfg.case_sensitive))
          len_hit[l-1] = 1'b0;
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= NEEDLE_MAX; l++) begin
      if (act_len == LEN_W'(l)) hit = len_hit[l-1];
    end
  end

endmodule

// ===== design/substring_search_first_last_core.sv =====
// Top level of the streaming substring search core (first or last match).
// Path: an item is registered in the input register at its transfer and processed
//   there; a string end then loads its result into the output register.
// Throughput: one character per cycle while no string end waits on a stalled result.
// Reset: synchronous, active high; clears configuration to defaults (case_sensitive 1)
//   and all per-string state; no result is pending after reset.
module substring_search_first_last_core
  import ssfl_pkg::*;
#(
  parameter int unsigned     NEEDLE_MAX = NEEDLE_MAX_DEF,
  parameter longint unsigned MAX_STRING = MAX_STRING_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write_enable,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NEEDLE_W-1:0]  cfg_data,
  // item channel
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [7:0]           symbol,
  input  logic                 end_of_string,
  input  logic                 empty_string,
  // result channel
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [POS_W-1:0]     match_position,
  output logic [1:0]           status
);

  cfg_t cfg;

  // input register
  logic       s1_valid;
  logic [7:0] s1_symbol;
  logic       s1_eos;
  logic       s1_empty;

  // per-string state
  logic [SEEN_W-1:0] chars_seen;
  logic              match_seen;
  logic [POS_W-1:0]  match_start;

  logic              s1_ends;
  logic              out_free;
  logic              s1_go;
  logic              take;
  logic              done;
  logic [LEN_W-1:0]  act_len;
  logic              hit;
  logic [SEEN_W:0]   pos_end;
  logic              full_window;
  logic [SEEN_W:0]   start;
  logic              recordable;
  logic              update;
  logic [SEEN_W-1:0] chars_seen_next;
  logic              match_seen_next;
  logic [POS_W-1:0]  match_start_next;
  status_t           status_next;
  logic [POS_W-1:0]  position_next;

  ssfl_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  // A length above the window depth acts as the full depth.
  assign act_len = (cfg.needle_length > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                            : cfg.needle_length;

  ssfl_window #(.NEEDLE_MAX(NEEDLE_MAX)) u_window (
    .clk     (clk),
    .rst     (rst),
    .advance (take),
    .clear   (done),
    .symbol  (s1_symbol),
    .cfg     (cfg),
    .act_len (act_len),
    .hit     (hit)
  );

  // Only a string end needs the output register; other items always move on.
  assign s1_ends    = s1_empty | s1_eos;
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1_ends || out_free);
  assign item_stall = s1_valid && !s1_go;
  assign take       = s1_go && !s1_empty;
  assign done       = s1_go && s1_ends;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_symbol <= symbol;
      s1_eos    <= end_of_string;
      s1_empty  <= empty_string;
    end
  end

  // A match is possible only once the string holds at least a needle's worth of
  // characters; its start is the index of this character minus the length plus one.
  assign pos_end     = {1'b0, chars_seen} + (SEEN_W+1)'(1);
  assign full_window = pos_end >= (SEEN_W+1)'(act_len);
  assign start       = pos_end - (SEEN_W+1)'(act_len);
  assign recordable  = (act_len != '0) && full_window && hit &&
                       (start <= (SEEN_W+1)'(POS_LIMIT)) && (64'(start) < MAX_STRING);
  // first mode keeps the earliest match, last mode replaces on every match
  assign update      = take && recordable && (!match_seen || cfg.find_last);

  always_comb begin
    chars_seen_next  = chars_seen;
    if (take && chars_seen != SEEN_LIMIT) chars_seen_next = chars_seen + SEEN_W'(1);
    match_seen_next  = match_seen | update;
    match_start_next = update ? start[POS_W-1:0] : match_start;
  end

  // status priority: empty haystack, then empty needle, then match or no match
  always_comb begin
    position_next = '0;
    if (chars_seen_next == '0) begin
      status_next = ST_EMPTY_HAY;
    end else if (act_len == '0) begin
      status_next = ST_EMPTY_NEEDLE;
    end else if (match_seen_next) begin
      status_next   = ST_FOUND;
      position_next = match_start_next;
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  // Drop all per-string state at a string end.
  always_ff @(posedge clk) begin
    if (rst || done) begin
      chars_seen  <= '0;
      match_seen  <= 1'b0;
      match_start <= '0;
    end else if (take) begin
      chars_seen  <= chars_seen_next;
      match_seen  <= match_seen_next;
      match_start <= match_start_next;
    end
  end

  // Output register: load on a string end, release once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      match_position <= position_next;
      status         <= status_next;
    end
  end

`ifndef SYNTH
  // Position is zero unless a match is reported.
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_FOUND) |-> (match_position == '0))
    else $error("nonzero position without a match");

  // A string end must wait while a result is held in a stalled output register.
  a_end_waits: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_ends && result_valid && result_stall) |-> item_stall)
    else $error("string end taken over a pending result");

  // String state starts over after each string end.
  a_state_clear: assert property (@(posedge clk) disable iff (rst)
    done |=> (chars_seen == '0 && !match_seen))
    else $error("string state not cleared at string end");

  // A string end always leaves a result in the output register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    done |=> result_valid)
    else $error("string end gave no result");
`endif

endmodule
